// ===== hdl/urxf_pkg.sv =====
// ----------------------------------------------------------------------------
// urxf_pkg
// Shared types and constants of the receive fifo with rts watermark control.
// ----------------------------------------------------------------------------
package urxf_pkg;

  // default fifo depth in bytes
  localparam int unsigned DepthDefault = 64;

  // fixed field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RTS_OFF_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RTS_ON_LEVEL  = 2'd1;

  // level reset values
  localparam logic [LevelW-1:0] RtsOffLevelRst = 7'd54;
  localparam logic [LevelW-1:0] RtsOnLevelRst  = 7'd44;

  // item opcodes
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } urxf_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic push;
    logic pop;
  } urxf_cmd_t;

endpackage

// ===== hdl/uart_rx_fifo_rts_watermark.sv =====
// ----------------------------------------------------------------------------
// uart_rx_fifo_rts_watermark
// Receive fifo of a serial port with rts watermark flow control.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid_i/in_ready_o) carries one beat per item: opcode_i
//   selects a received byte (rx_byte_i is pushed) or a read of the oldest byte
// - result channel (res_valid_o/res_ready_i) returns one beat per item with
//   the popped byte, its valid flag, the fill count, rts and the drop flag
// - configuration channel (cfg_valid_i/cfg_ready_o) writes the rts off level
//   (index 0) or on level (index 1); it is always ready, other indexes ignored
// - the result is valid in the cycle after the input beat is taken; the
//   pointers, count, rts and the registered store read update as it is taken
// - throughput: one item per cycle while the result side keeps taking beats;
//   a single result register sits between the two sides
// - a stalled result side holds the result and stops input only while it
//   stalls with a result waiting
// - reset empties the fifo, asserts rts and loads levels 54 and 44; the byte
//   store itself is not cleared
// ----------------------------------------------------------------------------
module uart_rx_fifo_rts_watermark #(
  parameter int unsigned DEPTH = urxf_pkg::DepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [urxf_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [urxf_pkg::ByteW-1:0]   out_byte_o,
  output logic                         out_valid_o,
  output logic [urxf_pkg::LevelW-1:0]  fill_count_o,
  output logic                         rts_asserted_o,
  output logic                         dropped_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [urxf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [urxf_pkg::LevelW-1:0]  cfg_data_i
);

  urxf_pkg::urxf_cmd_t cmd;

  // configuration writes are taken at once
  assign cfg_ready_o = 1'b1;

  // handshake controller
  urxf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .cmd_o       (cmd)
  );

  // fifo datapath
  urxf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rx_byte_i      (rx_byte_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .fill_count_o   (fill_count_o),
    .rts_asserted_o (rts_asserted_o),
    .dropped_o      (dropped_o)
  );

endmodule

// ===== hdl/urxf_ctrl.sv =====
// ----------------------------------------------------------------------------
// urxf_ctrl
// Handshake controller: takes an item beat, holds the result until taken.
// ----------------------------------------------------------------------------
module urxf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output urxf_pkg::urxf_cmd_t cmd_o
);

  urxf_pkg::urxf_state_e state_q, state_d;
  logic                  load;

  // a new beat may enter when no result waits or the waiting one leaves now
  assign in_ready_o  = (state_q == urxf_pkg::ST_IDLE) || res_ready_i;
  assign res_valid_o = (state_q == urxf_pkg::ST_HOLD);
  assign load        = in_valid_i && in_ready_o;

  // decode commands for the datapath
  assign cmd_o.push = load && (opcode_i == urxf_pkg::OP_RX_BYTE);
  assign cmd_o.pop  = load && (opcode_i == urxf_pkg::OP_READ);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      urxf_pkg::ST_IDLE: begin
        if (load) state_d = urxf_pkg::ST_HOLD;
      end
      urxf_pkg::ST_HOLD: begin
        if (load)             state_d = urxf_pkg::ST_HOLD;
        else if (res_ready_i) state_d = urxf_pkg::ST_IDLE;
      end
      default: state_d = urxf_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urxf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/urxf_dp.sv =====
// ----------------------------------------------------------------------------
// urxf_dp
// Datapath: byte store, pointers, fill count, rts watermark and result flags.
// ----------------------------------------------------------------------------
module urxf_dp #(
  parameter int unsigned DEPTH = urxf_pkg::DepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  urxf_pkg::urxf_cmd_t                cmd_i,
  input  logic [urxf_pkg::ByteW-1:0]         rx_byte_i,
  input  logic                               cfg_valid_i,
  input  logic [urxf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [urxf_pkg::LevelW-1:0]        cfg_data_i,
  output logic [urxf_pkg::ByteW-1:0]         out_byte_o,
  output logic                               out_valid_o,
  output logic [urxf_pkg::LevelW-1:0]        fill_count_o,
  output logic                               rts_asserted_o,
  output logic                               dropped_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > urxf_pkg::LevelW) ? CntW : urxf_pkg::LevelW;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [urxf_pkg::ByteW-1:0]  mem [DEPTH];
  logic [urxf_pkg::ByteW-1:0]  rd_data_q;
  logic [PtrW-1:0]             rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        rts_q, rts_d;
  logic [urxf_pkg::LevelW-1:0] off_level_q, on_level_q;
  logic                        ovalid_q, ovalid_d, drop_q, drop_d;
  logic                        not_full, not_empty, do_write, do_read;
  logic [CmpW-1:0]             cnt_ext, off_ext, on_ext;

  assign not_full  = (cnt_q != CntFull);
  assign not_empty = (cnt_q != '0);
  assign do_write  = cmd_i.push && not_full;
  assign do_read   = cmd_i.pop && not_empty;

  // watermark compare on the count before the push
  assign cnt_ext = CmpW'(cnt_q);
  assign off_ext = CmpW'(off_level_q);
  assign on_ext  = CmpW'(on_level_q);

  always_comb begin
    rts_d = rts_q;
    if (cmd_i.push) begin
      if (cnt_ext > off_ext) rts_d = 1'b0;
      if (cnt_ext < on_ext)  rts_d = 1'b1;
    end
  end

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_write) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      cnt_d    = cnt_q + 1'b1;
    end
    if (do_read) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end
  end

  // result flags
  always_comb begin
    ovalid_d = ovalid_q;
    drop_d   = drop_q;
    if (cmd_i.push || cmd_i.pop) begin
      ovalid_d = do_read;
      drop_d   = cmd_i.push && !not_full;
    end
  end

  // byte store with registered read port
  always_ff @(posedge clk_i) begin
    if (do_write) mem[wr_ptr_q] <= rx_byte_i;
    if (do_read)  rd_data_q     <= mem[rd_ptr_q];
  end

  // control state and configuration levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cnt_q       <= '0;
      rts_q       <= 1'b1;
      ovalid_q    <= 1'b0;
      drop_q      <= 1'b0;
      off_level_q <= urxf_pkg::RtsOffLevelRst;
      on_level_q  <= urxf_pkg::RtsOnLevelRst;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      rts_q    <= rts_d;
      ovalid_q <= ovalid_d;
      drop_q   <= drop_d;
      if (cfg_valid_i && (cfg_index_i == urxf_pkg::CFG_RTS_OFF_LEVEL)) begin
        off_level_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == urxf_pkg::CFG_RTS_ON_LEVEL)) begin
        on_level_q <= cfg_data_i;
      end
    end
  end

  // result fields
  assign out_byte_o     = ovalid_q ? rd_data_q : '0;
  assign out_valid_o    = ovalid_q;
  assign fill_count_o   = urxf_pkg::LevelW'(cnt_q);
  assign rts_asserted_o = rts_q;
  assign dropped_o      = drop_q;

  // count never exceeds the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("fill count above depth");

  // an empty fifo has matching pointers
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("pointers differ on empty fifo");

  // a push is dropped exactly when the fifo was full
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (drop_q == ($past(cnt_q) == CntFull)) && !ovalid_q)
    else $error("drop flag does not match full state");

  // a pop leaves rts unchanged and raises no drop flag
  a_pop_rts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> (rts_q == $past(rts_q)) && !drop_q)
    else $error("read changed rts or flagged a drop");

endmodule

// ===== tb/tb_uart_rx_fifo_rts_watermark.sv =====
// ----------------------------------------------------------------------------
// tb_uart_rx_fifo_rts_watermark
// Self-checking bench for the receive fifo with rts watermark flow control.
// A directed table covers empty reads, byte extremes, both watermark levels
// at their limits and register writes to unused indexes. Random bursts then
// fill, drain and mix traffic across several level settings and pacing
// modes. Every result beat is checked field by field against the table or a predictor.
// ----------------------------------------------------------------------------
module tb_uart_rx_fifo_rts_watermark;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth       = urxf_pkg::DepthDefault;
  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned PhaseItems  = 220;

  // register indexes with no register behind them
  localparam logic [urxf_pkg::CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [urxf_pkg::CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

  // pacing of the two sides
  typedef enum logic [1:0] {
    PACE_A,    // sender idles at 37 percent, receiver at 71
    PACE_B,    // sender idles at 71 percent, receiver at 37
    PACE_FREE  // neither side idles
  } pace_e;

  // one result beat
  typedef struct packed {
    logic [urxf_pkg::ByteW-1:0]  out_byte;
    logic                        out_valid;
    logic [urxf_pkg::LevelW-1:0] fill_count;
    logic                        rts_asserted;
    logic                        dropped;
  } fifo_res_t;

  // one row of the directed table: an item or a register write
  typedef struct packed {
    logic                         is_reg;
    logic                         op;
    logic [urxf_pkg::ByteW-1:0]   data;
    logic [urxf_pkg::CfgIdxW-1:0] idx;
    logic [urxf_pkg::LevelW-1:0]  level;
    logic                         typed;
    fifo_res_t                    res;
  } stim_row_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         opcode = urxf_pkg::OP_RX_BYTE;
  logic [urxf_pkg::ByteW-1:0]   rx_byte = '0;
  logic                         res_valid;
  logic                         res_ready = 1'b0;
  logic [urxf_pkg::ByteW-1:0]   out_byte;
  logic                         out_valid;
  logic [urxf_pkg::LevelW-1:0]  fill_count;
  logic                         rts_asserted;
  logic                         dropped;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [urxf_pkg::CfgIdxW-1:0] cfg_index = urxf_pkg::CFG_RTS_OFF_LEVEL;
  logic [urxf_pkg::LevelW-1:0]  cfg_data = '0;

  // predictor state
  logic [urxf_pkg::ByteW-1:0]  fifo_mem [Depth];
  int unsigned                 fifo_rd;
  int unsigned                 fifo_wr;
  int unsigned                 fifo_count;
  logic                        fifo_rts;
  logic [urxf_pkg::LevelW-1:0] off_level;
  logic [urxf_pkg::LevelW-1:0] on_level;

  fifo_res_t           res_exp_q [$];
  stim_row_t           dir_rows [$];
  pace_e               pace = PACE_A;
  bit                  calm = 1'b0;
  int unsigned         items_sent = 0;
  int unsigned         err_count = 0;
  int unsigned         cycles = 0;

  uart_rx_fifo_rts_watermark #(
    .DEPTH(Depth)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .rx_byte_i     (rx_byte),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .out_byte_o    (out_byte),
    .out_valid_o   (out_valid),
    .fill_count_o  (fill_count),
    .rts_asserted_o(rts_asserted),
    .dropped_o     (dropped),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor: rts update on a received byte, then push, drop or pop
  function automatic fifo_res_t predict_item(input logic op,
                                             input logic [urxf_pkg::ByteW-1:0] b);
    fifo_res_t r;
    r = '0;
    if (op == urxf_pkg::OP_RX_BYTE) begin
      if (fifo_count > off_level) fifo_rts = 1'b0;
      if (fifo_count < on_level) fifo_rts = 1'b1;
      if (fifo_count < Depth) begin
        fifo_mem[fifo_wr] = b;
        fifo_count++;
        fifo_wr = (fifo_wr == Depth - 1) ? 0 : fifo_wr + 1;
      end else begin
        r.dropped = 1'b1;
      end
    end else if (fifo_count != 0) begin
      r.out_byte  = fifo_mem[fifo_rd];
      r.out_valid = 1'b1;
      fifo_count--;
      fifo_rd = (fifo_rd == Depth - 1) ? 0 : fifo_rd + 1;
    end
    r.fill_count   = fifo_count[urxf_pkg::LevelW-1:0];
    r.rts_asserted = fifo_rts;
    return r;
  endfunction

  function automatic fifo_res_t res_of(input logic [urxf_pkg::ByteW-1:0] b,
                                       input logic v,
                                       input logic [urxf_pkg::LevelW-1:0] f,
                                       input logic r,
                                       input logic d);
    fifo_res_t x;
    x = '{out_byte: b, out_valid: v, fill_count: f, rts_asserted: r, dropped: d};
    return x;
  endfunction

  function automatic stim_row_t item_row(input logic op,
                                         input logic [urxf_pkg::ByteW-1:0] b);
    stim_row_t s;
    s = '0;
    s.op   = op;
    s.data = b;
    return s;
  endfunction

  function automatic stim_row_t checked_row(input logic op,
                                            input logic [urxf_pkg::ByteW-1:0] b,
                                            input fifo_res_t e);
    stim_row_t s;
    s = item_row(op, b);
    s.typed = 1'b1;
    s.res   = e;
    return s;
  endfunction

  function automatic stim_row_t reg_row(input logic [urxf_pkg::CfgIdxW-1:0] idx,
                                        input logic [urxf_pkg::LevelW-1:0] v);
    stim_row_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.idx    = idx;
    s.level  = v;
    return s;
  endfunction

  function automatic int unsigned send_pct();
    case (pace)
      PACE_A:  return 37;
      PACE_B:  return 71;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_pct();
    case (pace)
      PACE_A:  return 71;
      PACE_B:  return 37;
      default: return 0;
    endcase
  endfunction

  // one input beat; the expectation is recorded at the accepting edge
  task automatic send_item(input logic op, input logic [urxf_pkg::ByteW-1:0] b,
                           input logic typed, input fifo_res_t typed_res);
    fifo_res_t r;
    while (!calm && $urandom_range(0, 99) < send_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_item(op, b);
    res_exp_q.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // drop valid and wait until every expected beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (res_exp_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register write, only issued with the block idle
  task automatic write_reg(input logic [urxf_pkg::CfgIdxW-1:0] idx,
                           input logic [urxf_pkg::LevelW-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == urxf_pkg::CFG_RTS_OFF_LEVEL) off_level = v;
    else if (idx == urxf_pkg::CFG_RTS_ON_LEVEL) on_level = v;
  endtask

  // random burst: fills, drains, mixed traffic and plain noise
  task automatic run_burst();
    int unsigned kind;
    int unsigned n;
    int unsigned push_pct;
    logic        op;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(1, 70);
    calm = ($urandom_range(0, 7) == 0);
    push_pct = (kind <= 2) ? 100 : (kind <= 5) ? 0 : (kind <= 8) ? 55 : 50;
    repeat (n) begin
      op = ($urandom_range(0, 99) < push_pct) ? urxf_pkg::OP_RX_BYTE : urxf_pkg::OP_READ;
      send_item(op, urxf_pkg::ByteW'($urandom_range(0, 255)), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  task automatic chk(input string name, input logic [urxf_pkg::ByteW-1:0] e,
                     input logic [urxf_pkg::ByteW-1:0] a);
    if (a !== e) begin
      if (err_count < 10) $display("mismatch %s: expected %0h, got %0h", name, e, a);
      err_count++;
    end
  endtask

  task automatic check_result();
    fifo_res_t e;
    if (res_exp_q.size() == 0) begin
      if (err_count < 10) $display("result beat with nothing expected");
      err_count++;
      return;
    end
    e = res_exp_q.pop_front();
    chk("out_byte", e.out_byte, out_byte);
    chk("out_valid", e.out_valid, out_valid);
    chk("fill_count", e.fill_count, fill_count);
    chk("rts_asserted", e.rts_asserted, rts_asserted);
    chk("dropped", e.dropped, dropped);
  endtask

  // result side: check the beat taken at this edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) check_result();
    if (calm || pace == PACE_FREE) res_ready <= 1'b1;
    else res_ready <= ($urandom_range(0, 99) >= recv_pct());
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("uart_rx_fifo_rts_watermark regression: fail");
      $finish;
    end
  end

  // directed table
  task automatic build_table();
    // empty read and byte extremes at the reset levels
    dir_rows.push_back(checked_row(urxf_pkg::OP_READ, 8'h00,
                                   res_of(8'h00, 1'b0, 7'd0, 1'b1, 1'b0)));
    dir_rows.push_back(checked_row(urxf_pkg::OP_RX_BYTE, 8'h00,
                                   res_of(8'h00, 1'b0, 7'd1, 1'b1, 1'b0)));
    dir_rows.push_back(checked_row(urxf_pkg::OP_RX_BYTE, 8'hFF,
                                   res_of(8'h00, 1'b0, 7'd2, 1'b1, 1'b0)));
    dir_rows.push_back(checked_row(urxf_pkg::OP_READ, 8'h00,
                                   res_of(8'h00, 1'b1, 7'd1, 1'b1, 1'b0)));
    dir_rows.push_back(checked_row(urxf_pkg::OP_READ, 8'hFF,
                                   res_of(8'hFF, 1'b1, 7'd0, 1'b1, 1'b0)));
    dir_rows.push_back(checked_row(urxf_pkg::OP_READ, 8'hAA,
                                   res_of(8'h00, 1'b0, 7'd0, 1'b1, 1'b0)));
    // both levels hit: the assert test wins
    dir_rows.push_back(reg_row(urxf_pkg::CFG_RTS_OFF_LEVEL, 7'd0));
    dir_rows.push_back(reg_row(urxf_pkg::CFG_RTS_ON_LEVEL, 7'd64));
    dir_rows.push_back(item_row(urxf_pkg::OP_RX_BYTE, 8'hA5));
    dir_rows.push_back(item_row(urxf_pkg::OP_RX_BYTE, 8'h5A));
    dir_rows.push_back(item_row(urxf_pkg::OP_RX_BYTE, 8'h3C));
    // release only, then reads leave rts alone
    dir_rows.push_back(reg_row(urxf_pkg::CFG_RTS_ON_LEVEL, 7'd0));
    dir_rows.push_back(item_row(urxf_pkg::OP_RX_BYTE, 8'h80));
    dir_rows.push_back(item_row(urxf_pkg::OP_READ, 8'h00));
    dir_rows.push_back(item_row(urxf_pkg::OP_READ, 8'h00));
    // levels at their top
    dir_rows.push_back(reg_row(urxf_pkg::CFG_RTS_OFF_LEVEL, 7'd64));
    dir_rows.push_back(reg_row(urxf_pkg::CFG_RTS_ON_LEVEL, 7'd64));
    dir_rows.push_back(item_row(urxf_pkg::OP_RX_BYTE, 8'h7F));
    dir_rows.push_back(reg_row(urxf_pkg::CFG_RTS_OFF_LEVEL, 7'd127));
    dir_rows.push_back(reg_row(urxf_pkg::CFG_RTS_ON_LEVEL, 7'd0));
    dir_rows.push_back(item_row(urxf_pkg::OP_RX_BYTE, 8'h01));
    dir_rows.push_back(item_row(urxf_pkg::OP_READ, 8'h00));
    dir_rows.push_back(item_row(urxf_pkg::OP_READ, 8'h00));
    dir_rows.push_back(item_row(urxf_pkg::OP_READ, 8'h00));
    dir_rows.push_back(item_row(urxf_pkg::OP_READ, 8'h00));
    // unused register indexes change nothing
    dir_rows.push_back(reg_row(CFG_SPARE_2, 7'h7F));
    dir_rows.push_back(reg_row(CFG_SPARE_3, 7'h00));
    dir_rows.push_back(item_row(urxf_pkg::OP_RX_BYTE, 8'h55));
    dir_rows.push_back(item_row(urxf_pkg::OP_READ, 8'h00));
  endtask

  // stimulus
  initial begin
    int unsigned ph;
    int unsigned target;
    logic [urxf_pkg::LevelW-1:0] offs [6];
    logic [urxf_pkg::LevelW-1:0] ons  [6];
    offs = '{7'd54, 7'd64, 7'd0, 7'd20, 7'd127, 7'd0};
    ons  = '{7'd44, 7'd0, 7'd64, 7'd10, 7'd127, 7'd0};
    fifo_rd    = 0;
    fifo_wr    = 0;
    fifo_count = 0;
    fifo_rts   = 1'b1;
    off_level  = urxf_pkg::RtsOffLevelRst;
    on_level   = urxf_pkg::RtsOnLevelRst;
    build_table();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) write_reg(dir_rows[i].idx, dir_rows[i].level);
      else send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases over level settings and pacing modes
    for (ph = 0; ph < 6; ph++) begin
      pace = (ph < 2) ? PACE_A : (ph < 4) ? PACE_B : PACE_FREE;
      if (ph == 5) begin
        offs[ph] = urxf_pkg::LevelW'($urandom_range(0, 64));
        ons[ph]  = urxf_pkg::LevelW'($urandom_range(0, 64));
        write_reg(CFG_SPARE_2, urxf_pkg::LevelW'($urandom_range(0, 127)));
      end
      write_reg(urxf_pkg::CFG_RTS_OFF_LEVEL, offs[ph]);
      write_reg(urxf_pkg::CFG_RTS_ON_LEVEL, ons[ph]);
      target = items_sent + PhaseItems;
      // full fifo with drops, then drain past empty, wrapping the pointers
      if (ph == 0) begin
        repeat (Depth + 2) begin
          send_item(urxf_pkg::OP_RX_BYTE, urxf_pkg::ByteW'($urandom_range(0, 255)),
                    1'b0, '0);
        end
        repeat (Depth + 2) begin
          send_item(urxf_pkg::OP_READ, urxf_pkg::ByteW'($urandom_range(0, 255)),
                    1'b0, '0);
        end
      end
      while (items_sent < target) run_burst();
    end

    // drain and finish
    wait_drained();
    repeat (4) @(posedge clk);
    if (err_count == 0) $display("uart_rx_fifo_rts_watermark regression: pass");
    else $display("uart_rx_fifo_rts_watermark regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/urxf_pkg.sv
hdl/urxf_ctrl.sv
hdl/urxf_dp.sv
hdl/uart_rx_fifo_rts_watermark.sv
tb/tb_uart_rx_fifo_rts_watermark.sv
